/* rtl/etg_pkg.sv */
// Shared types and codes for the eased tween generator.
// Transfer payload structs, op and curve codes, default parameter values.
// No dependencies.
package etg_pkg;

    localparam int TIME_BITS_DEF       = 32;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int COS_TABLE_DEPTH_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam logic [2:0] CURVE_LINEAR = 3'd0;
    localparam logic [2:0] CURVE_SQUARE = 3'd1;
    localparam logic [2:0] CURVE_SQRT   = 3'd2;
    localparam logic [2:0] CURVE_SMOOTH = 3'd3;
    localparam logic [2:0] CURVE_COS    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CURVE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd1;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        now;
        logic signed [15:0] begin_value;
        logic signed [15:0] end_value;
        logic [31:0]        span;
    } in_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic               finished;
    } out_t;

endpackage

/* rtl/etg_cos_rom.sv */
// Raised cosine table, sin^2(pi*k/DEPTH) in Q1.FRAC_BITS, with registered read.
// Content is built at elaboration from a truncated integer sine series.
// Depends on nothing outside this file.
module etg_cos_rom #(
    parameter int FRAC_BITS       = 16,
    parameter int COS_TABLE_DEPTH = 256,
    parameter int AW              = $clog2(COS_TABLE_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic [AW-1:0]    addr,
    output logic [FRAC_BITS:0] rd_data
);

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] ONE_Q  = 64'd1 << FRAC_BITS;

    typedef logic [FRAC_BITS:0] rom_arr_t [0:COS_TABLE_DEPTH];

    function automatic logic [63:0] half_turn_sin(input logic [63:0] u30);
        logic [63:0]        th;
        logic [63:0]        th2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [65:0] sum;
        th   = (PI_Q30 * u30) >> 30;
        th2  = (th * th) >> 30;
        term = th;
        sum  = $signed({2'b00, th});
        for (int n = 1; n <= 5; n++) begin
            prod = (term * th2) >> 30;
            case (n)
                1: term = prod / 64'd6;
                2: term = prod / 64'd20;
                3: term = prod / 64'd42;
                4: term = prod / 64'd72;
                default: term = prod / 64'd110;
            endcase
            if (n % 2 == 1) begin
                sum = sum - $signed({2'b00, term});
            end else begin
                sum = sum + $signed({2'b00, term});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed(66'd1 << 30)) begin
            sum = $signed(66'd1 << 30);
        end
        return sum[63:0];
    endfunction

    function automatic rom_arr_t gen_rom();
        rom_arr_t    r;
        logic [63:0] m;
        logic [63:0] s;
        logic [63:0] g;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            m = 64'(k);
            if (2 * k > COS_TABLE_DEPTH) begin
                m = 64'(COS_TABLE_DEPTH - k);
            end
            s = half_turn_sin((m << 30) / COS_TABLE_DEPTH);
            g = (s * s) >> (60 - FRAC_BITS);
            r[k] = (g > ONE_Q) ? ONE_Q[FRAC_BITS:0] : g[FRAC_BITS:0];
        end
        return r;
    endfunction

    localparam rom_arr_t ROM = gen_rom();

    always_ff @(posedge aclk) begin
        rd_data <= ROM[addr];
    end

endmodule

/* rtl/eased_tween_generator.sv */
// An active tick runs the bit-serial divider (skipped when t saturates) and then the
// curve: square root runs a bit-serial loop, the others reuse one registered multiplier
// 1 to 3 times.
// Throughput: one item at a time; a tick is accepted again in the cycle after its
// result is loaded, a stalled result holds the input; start/stop/idle ticks stay in S_IDLE.
// Reset (aresetn low, synchronous): inactive, stored operands and config zero.
// Top level; uses etg_pkg and etg_cos_rom.
module eased_tween_generator #(
    parameter int TIME_BITS       = etg_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS       = etg_pkg::FRAC_BITS_DEF,
    parameter int COS_TABLE_DEPTH = etg_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [etg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [etg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  etg_pkg::in_t                     s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output etg_pkg::out_t                    m_data
);
    import etg_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int GW    = F + 1;
    localparam int CW    = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int MW    = (F + 3 > 17) ? F + 3 : 17;
    localparam int PW    = 2 * MW;
    localparam int SW    = 2 * F + 1;
    localparam int AW    = $clog2(COS_TABLE_DEPTH + 1);
    localparam int CNT_W = $clog2(F + 1);
    localparam int NW    = F + 18;
    localparam logic [GW-1:0] ONE = GW'(1) << F;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_SEL, S_MUL, S_SQ, S_SMOOTH, S_SQRT,
        S_COS_POS, S_COS_A, S_COS_B, S_COS_C, S_COS_D, S_IM, S_FIN
    } state_t;

    state_t               state_reg, ret_reg;
    logic                 active_reg;
    logic [TIME_BITS-1:0] start_reg, now_reg;
    logic signed [15:0]   begin_reg, end_reg, lo_reg;
    logic [31:0]          span_reg;
    logic [2:0]           curve_reg;
    logic                 repeat_reg;
    logic [CW-1:0]        rem_reg;
    logic [GW-1:0]        g_reg, f_reg, a_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 fin_reg;
    logic [16:0]          d_reg;
    logic [MW-1:0]        mul_a_reg, mul_b_reg;
    logic [PW-1:0]        prod_reg;
    logic [SW-1:0]        x_reg, r_reg, b_reg;
    logic [AW-1:0]        addr_reg;
    logic [F-1:0]         frac_reg;
    logic                 clip_reg, up_reg;
    logic                 m_valid_reg;
    out_t                 m_data_reg;

    logic [GW-1:0]        rom_q;
    logic [TIME_BITS-1:0] now_tb, diff;
    logic [CW-1:0]        diff_cw, span_cw;
    logic [CW:0]          rem2;
    logic                 q_bit;
    logic [GW-1:0]        q_next;
    logic                 desc;
    logic [GW-1:0]        t_full;
    logic [SW:0]          rb;
    logic [AW-1:0]        idx;
    logic signed [NW-1:0] num;
    logic [NW-1:0]        mag;
    logic [16:0]          mq;
    logic signed [15:0]   v;

    etg_cos_rom #(
        .FRAC_BITS(FRAC_BITS),
        .COS_TABLE_DEPTH(COS_TABLE_DEPTH),
        .AW(AW)
    ) u_rom (
        .aclk(aclk),
        .addr(addr_reg),
        .rd_data(rom_q)
    );

    always_comb begin
        now_tb    = TIME_BITS'(CW'(s_data.now));
        diff      = now_tb - start_reg;
        diff_cw   = CW'(diff);
        span_cw   = CW'(span_reg);
        rem2      = {rem_reg, 1'b0};
        q_bit     = rem2 >= {1'b0, span_cw};
        q_next    = {f_reg[GW-2:0], q_bit};
        desc      = !(begin_reg < end_reg);
        t_full    = desc ? '0 : ONE;
        rb        = {1'b0, r_reg} + {1'b0, b_reg};
        idx       = prod_reg[F+AW-1:F];
        num       = $signed({{2{lo_reg[15]}}, lo_reg, {F{1'b0}}})
                  + $signed({2'b00, prod_reg[F+15:0]});
        mag       = NW'(0) - NW'(num);
        mq        = mag[F+16:F];
        v         = num[NW-1] ? 16'(17'(0) - mq) : num[F+15:F];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PW'(mul_a_reg) * PW'(mul_b_reg);
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            active_reg  <= 1'b0;
            start_reg   <= '0;
            begin_reg   <= '0;
            end_reg     <= '0;
            span_reg    <= '0;
            curve_reg   <= CURVE_LINEAR;
            repeat_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CURVE:  curve_reg  <= cfg_data;
                    REG_REPEAT: repeat_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        case (s_data.op)
                            OP_START: begin
                                begin_reg  <= s_data.begin_value;
                                end_reg    <= s_data.end_value;
                                span_reg   <= s_data.span;
                                start_reg  <= now_tb;
                                active_reg <= 1'b1;
                            end
                            OP_STOP: active_reg <= 1'b0;
                            OP_TICK: begin
                                if (active_reg) begin
                                    now_reg <= now_tb;
                                    fin_reg <= diff_cw > span_cw;
                                    lo_reg  <= desc ? end_reg : begin_reg;
                                    d_reg   <= desc
                                        ? ($signed({begin_reg[15], begin_reg})
                                           - $signed({end_reg[15], end_reg}))
                                        : ($signed({end_reg[15], end_reg})
                                           - $signed({begin_reg[15], begin_reg}));
                                    rem_reg <= diff_cw;
                                    cnt_reg <= CNT_W'(F - 1);
                                    f_reg   <= '0;
                                    if (span_cw == '0 || diff_cw >= span_cw) begin
                                        g_reg     <= t_full;
                                        state_reg <= S_SEL;
                                    end else begin
                                        state_reg <= S_DIV;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (q_bit) begin
                        rem_reg <= CW'(rem2 - {1'b0, span_cw});
                    end else begin
                        rem_reg <= rem2[CW-1:0];
                    end
                    f_reg <= q_next;
                    if (cnt_reg == '0) begin
                        g_reg     <= desc ? ONE - q_next : q_next;
                        state_reg <= S_SEL;
                    end else begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                S_SEL: begin
                    case (curve_reg)
                        CURVE_SQUARE, CURVE_SMOOTH: begin
                            mul_a_reg <= MW'(g_reg);
                            mul_b_reg <= MW'(g_reg);
                            ret_reg   <= S_SQ;
                            state_reg <= S_MUL;
                        end
                        CURVE_SQRT: begin
                            x_reg     <= {g_reg, {F{1'b0}}};
                            r_reg     <= '0;
                            b_reg     <= SW'(1) << (2 * F);
                            cnt_reg   <= CNT_W'(F);
                            state_reg <= S_SQRT;
                        end
                        CURVE_COS: begin
                            mul_a_reg <= MW'(g_reg);
                            mul_b_reg <= MW'(COS_TABLE_DEPTH);
                            ret_reg   <= S_COS_POS;
                            state_reg <= S_MUL;
                        end
                        default: begin
                            f_reg     <= g_reg;
                            state_reg <= S_IM;
                        end
                    endcase
                end
                S_MUL: state_reg <= ret_reg;
                S_SQ: begin
                    if (curve_reg == CURVE_SQUARE) begin
                        f_reg     <= prod_reg[F+GW-1:F];
                        state_reg <= S_IM;
                    end else begin
                        mul_a_reg <= MW'(prod_reg[F+GW-1:F]);
                        mul_b_reg <= MW'({2'b00, ONE} + {1'b0, ONE, 1'b0}
                                         - {1'b0, g_reg, 1'b0});
                        ret_reg   <= S_SMOOTH;
                        state_reg <= S_MUL;
                    end
                end
                S_SMOOTH: begin
                    f_reg     <= prod_reg[F+GW-1:F];
                    state_reg <= S_IM;
                end
                S_SQRT: begin
                    if ({1'b0, x_reg} >= rb) begin
                        x_reg <= SW'({1'b0, x_reg} - rb);
                        r_reg <= (r_reg >> 1) + b_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    b_reg <= b_reg >> 2;
                    if (cnt_reg == '0) begin
                        state_reg <= S_COS_D;
                        clip_reg  <= 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                S_COS_POS: begin
                    frac_reg  <= prod_reg[F-1:0];
                    clip_reg  <= idx >= AW'(COS_TABLE_DEPTH);
                    addr_reg  <= (idx >= AW'(COS_TABLE_DEPTH))
                                 ? AW'(COS_TABLE_DEPTH) : idx;
                    state_reg <= S_COS_A;
                end
                S_COS_A: begin
                    if (!clip_reg) begin
                        addr_reg <= addr_reg + AW'(1);
                    end
                    state_reg <= S_COS_B;
                end
                S_COS_B: begin
                    a_reg <= rom_q;
                    if (clip_reg) begin
                        f_reg     <= rom_q;
                        state_reg <= S_IM;
                    end else begin
                        state_reg <= S_COS_C;
                    end
                end
                S_COS_C: begin
                    up_reg    <= rom_q >= a_reg;
                    mul_a_reg <= MW'(rom_q >= a_reg ? rom_q - a_reg : a_reg - rom_q);
                    mul_b_reg <= MW'(frac_reg);
                    ret_reg   <= S_COS_D;
                    state_reg <= S_MUL;
                    clip_reg  <= 1'b0;
                end
                S_COS_D: begin
                    if (clip_reg) begin
                        f_reg <= r_reg[GW-1:0];
                    end else if (up_reg) begin
                        f_reg <= a_reg + prod_reg[F+GW-1:F];
                    end else begin
                        f_reg <= a_reg - prod_reg[F+GW-1:F];
                    end
                    state_reg <= S_IM;
                end
                S_IM: begin
                    mul_a_reg <= MW'(f_reg);
                    mul_b_reg <= MW'(d_reg);
                    ret_reg   <= S_FIN;
                    state_reg <= S_MUL;
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg         <= 1'b1;
                        m_data_reg.value    <= v;
                        m_data_reg.finished <= fin_reg;
                        if (fin_reg) begin
                            if (repeat_reg) begin
                                start_reg <= now_reg;
                            end else begin
                                active_reg <= 1'b0;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/etg_checker.sv */
// Port-level checks for the eased tween generator, bound to the top level.
// Uses etg_pkg for the op codes.
module etg_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input etg_pkg::in_t   s_data,
    input logic           m_valid,
    input logic           m_ready,
    input etg_pkg::out_t  m_data
);
    import etg_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result one cycle after a transfer");

    a_ctrl_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.op == OP_START || s_data.op == OP_STOP)
        |=> s_ready)
        else $error("start or stop did not complete in one cycle");

endmodule

bind eased_tween_generator etg_checker u_etg_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data(s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data(m_data)
);

/* verif/tb_eased_tween_generator.sv */
// Self-checking testbench for eased_tween_generator: random valid/ready traffic,
// an in-bench predictor of the tween curves and a scoreboard of expected results.
// Depends on etg_pkg and the eased_tween_generator RTL.
`timescale 1ns / 100ps

module tb_eased_tween_generator;
    import etg_pkg::*;

    localparam int ONE_Q = 65536;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    in_t s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    eased_tween_generator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    in_t pending_items[$];
    out_t expected_results[$];
    int mismatches = 0;

    // predictor state
    longint unsigned cos_rom[0:256];
    logic [2:0] curve_sel = CURVE_LINEAR;
    logic repeat_on = 1'b0;
    logic tween_active = 1'b0;
    logic [31:0] tween_start = '0;
    logic signed [15:0] tween_begin = '0;
    logic signed [15:0] tween_end = '0;
    logic [31:0] tween_span = '0;

    // pacing controls
    int send_gap = 0;
    int recv_gap = 0;
    bit send_calm = 0;
    bit recv_calm = 0;
    bit stall_request = 0;
    bit stall_done = 0;
    int stall_left = 0;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic void enqueue_item(in_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic longint unsigned sin_half_turn(longint unsigned u30);
        longint unsigned th, th2, term;
        longint sum;
        th = (64'd3373259426 * u30) >> 30;
        th2 = (th * th) >> 30;
        term = th;
        sum = longint'(th);
        for (int n = 1; n <= 5; n++) begin
            term = ((term * th2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
        return longint'(sum);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned eased(longint unsigned t);
        longint unsigned t2, pos, idx, frac, a, b;
        case (curve_sel)
            CURVE_SQUARE: return (t * t) >> 16;
            CURVE_SQRT: return int_sqrt(t << 16);
            CURVE_SMOOTH: begin
                t2 = (t * t) >> 16;
                return (t2 * (3 * ONE_Q - 2 * t)) >> 16;
            end
            CURVE_COS: begin
                pos = t * 256;
                idx = pos >> 16;
                frac = pos & (ONE_Q - 1);
                if (idx >= 256) return cos_rom[256];
                a = cos_rom[idx];
                b = cos_rom[idx + 1];
                if (b >= a) return a + (((b - a) * frac) >> 16);
                return a - (((a - b) * frac) >> 16);
            end
            default: return t;
        endcase
    endfunction

    function automatic void predict_tween(in_t it);
        logic [31:0] elapsed;
        longint unsigned t, f, d;
        longint lo, hi, num, v;
        out_t r;
        if (it.op == OP_START) begin
            tween_begin = it.begin_value;
            tween_end = it.end_value;
            tween_span = it.span;
            tween_start = it.now;
            tween_active = 1'b1;
            return;
        end
        if (it.op == OP_STOP) begin
            tween_active = 1'b0;
            return;
        end
        if (it.op != OP_TICK || !tween_active) return;
        elapsed = it.now - tween_start;
        if (tween_span == 0 || elapsed >= tween_span) t = ONE_Q;
        else t = ({32'd0, elapsed} << 16) / {32'd0, tween_span};
        if (tween_begin < tween_end) begin
            lo = tween_begin;
            hi = tween_end;
            f = eased(t);
        end else begin
            lo = tween_end;
            hi = tween_begin;
            f = eased(ONE_Q - t);
        end
        d = hi - lo;
        num = lo * ONE_Q + longint'(f * d);
        if (num >= 0) v = num >>> 16;
        else v = -((-num) >>> 16);
        r.value = v[15:0];
        r.finished = elapsed > tween_span;
        if (r.finished) begin
            if (repeat_on) tween_start = it.now;
            else tween_active = 1'b0;
        end
        expected_results.insert(expected_results.size(), r);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
                send_gap <= send_calm ? 0 : $urandom_range(0, 10);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (stall_request && !stall_done) begin
            stall_left <= 300;
            stall_done <= 1;
            m_ready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            recv_gap <= recv_calm ? 0 : $urandom_range(0, 10);
            m_ready <= recv_calm;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && s_valid && s_ready) predict_tween(s_data);
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result value=%0d finished=%0d",
                       m_data.value, m_data.finished);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.value !== want.value) begin
                    $error("value: expected %0d, actual %0d", want.value, m_data.value);
                    mismatches++;
                end
                if (m_data.finished !== want.finished) begin
                    $error("finished: expected %0d, actual %0d",
                           want.finished, m_data.finished);
                    mismatches++;
                end
            end
        end
    end

    function automatic in_t mk_item(logic [1:0] op, logic [31:0] now,
                                    logic [15:0] b, logic [15:0] e, logic [31:0] span);
        in_t it;
        it.op = op;
        it.now = now;
        it.begin_value = b;
        it.end_value = e;
        it.span = span;
        return it;
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CURVE: curve_sel = val;
            REG_REPEAT: repeat_on = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // one well-formed tween: start, ticks toward and sometimes past the end, sometimes a stop
    task automatic queue_tween(ref int count);
        logic [31:0] stamp, span, step_max;
        int ticks;
        case ($urandom_range(0, 9))
            0: span = 0;
            1: span = $urandom;
            2: span = $urandom_range(1, 3);
            default: span = $urandom_range(1, 400);
        endcase
        stamp = $urandom;
        enqueue_item(mk_item(OP_START, stamp, pick_level(), pick_level(), span));
        ticks = $urandom_range(3, 12);
        step_max = span / 4 + 1;
        count += 1;
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 7) == 0) stamp += span + $urandom_range(0, 3);
            else stamp += $urandom_range(0, step_max);
            enqueue_item(mk_item(OP_TICK, stamp, $urandom, $urandom, $urandom));
            count += 1;
        end
        if ($urandom_range(0, 4) == 0) begin
            enqueue_item(mk_item(OP_STOP, $urandom, $urandom, $urandom, $urandom));
            count += 1;
        end
    endtask

    initial begin
        int count;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        for (int k = 0; k <= 256; k++) begin
            longint unsigned m, s, g;
            m = k;
            if (2 * m > 256) m = 256 - m;
            s = sin_half_turn((m << 30) / 256);
            g = (s * s) >> 44;
            cos_rom[k] = g > ONE_Q ? ONE_Q : g;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle ticks, extremes, reversed range, zero span, wrap, stop, bad op
        enqueue_item(mk_item(OP_TICK, 32'd5, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_START, 32'd0, 16'h8000, 16'h7FFF, 32'd100));
        enqueue_item(mk_item(OP_TICK, 32'd0, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_TICK, 32'd50, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_TICK, 32'd100, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_TICK, 32'd101, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_TICK, 32'd102, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_START, 32'hFFFF_FFF0, 16'h7FFF, 16'h8000,
                             32'hFFFF_FFFF));
        enqueue_item(mk_item(OP_TICK, 32'h0000_0010, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_START, 32'd7, 16'd1234, 16'd1234, 32'd0));
        enqueue_item(mk_item(OP_TICK, 32'd7, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_TICK, 32'd8, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_START, 32'd0, 16'hFFFF, 16'd3, 32'd9));
        enqueue_item(mk_item(OP_TICK, 32'd4, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(2'd3, 32'd5, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_STOP, 32'd6, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_TICK, 32'd6, 16'h0, 16'h0, 32'd0));
        enqueue_item(mk_item(OP_STOP, 32'd6, 16'h0, 16'h0, 32'd0));
        drain();

        for (int phase = 0; phase < 16; phase++) begin
            write_reg(REG_CURVE, CFG_DATA_W'(phase % 8));
            write_reg(REG_REPEAT, CFG_DATA_W'(phase / 8));
            write_reg(CFG_IDX_W'(2 + phase % 2), CFG_DATA_W'($urandom));
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                send_calm = 1;
                stall_request = 1;
            end
            count = 0;
            while (count < 108) begin
                if ($urandom_range(0, 9) == 0) begin
                    enqueue_item(mk_item($urandom, $urandom, $urandom,
                                         $urandom, $urandom));
                    count += 1;
                end else begin
                    queue_tween(count);
                end
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
